// ===== rtl/core/pfvb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfvb_pkg
// Shared types and constants of the pic/flip velocity blend block: field
// layout of the stream words, request codes and pipeline stage enables.
// ----------------------------------------------------------------------------
`default_nettype none

package pfvb_pkg;

  localparam int FaceWidth  = 32;
  localparam int IdxWidth   = 6;
  localparam int PosWidth   = 16;
  localparam int FracBits   = 16;
  localparam int AlphaWidth = 17;
  localparam int NumAxes    = 3;

  localparam logic [AlphaWidth-1:0] AlphaOne   = 17'd65536;
  localparam logic [AlphaWidth-1:0] AlphaReset = 17'd62259;

  // register index, taken from paddr[2]
  localparam logic RegBlendAlpha = 1'b0;

  // request stream layout
  localparam int InDataWidth  = 200;
  localparam int InUserWidth  = 4;
  localparam int ReqTypeLsb   = 0;
  localparam int AxisLsb      = 2;
  localparam int FaceILsb     = 0;
  localparam int FaceJLsb     = 6;
  localparam int FaceKLsb     = 12;
  localparam int LoadValueLsb = 18;
  localparam int PosXLsb      = 50;
  localparam int PosYLsb      = 66;
  localparam int PosZLsb      = 82;
  localparam int OldXLsb      = 98;
  localparam int OldYLsb      = 130;
  localparam int OldZLsb      = 162;

  typedef enum logic [1:0] {
    REQ_LOAD_CUR = 2'd0,
    REQ_LOAD_SAV = 2'd1,
    REQ_PARTICLE = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // load enables of the pipeline registers behind the request stage
  typedef struct packed {
    logic mem;
    logic mul1;
    logic sum1;
    logic mul2;
    logic res;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfvb_face_mem.sv =====
// ----------------------------------------------------------------------------
// pfvb_face_mem
// Face velocity store of one axis: current and saved grid, one write port
// and two registered read ports (lower and upper face of a cell).
// ----------------------------------------------------------------------------
`default_nettype none

module pfvb_face_mem #(
  parameter int DEPTH = 33792,
  parameter int AW    = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_cur_i,
  input  wire logic                              we_sav_i,
  input  wire logic [AW-1:0]                     waddr_i,
  input  wire logic [pfvb_pkg::FaceWidth-1:0]    wdata_i,
  input  wire logic                              re_i,
  input  wire logic [AW-1:0]                     raddr_lo_i,
  input  wire logic [AW-1:0]                     raddr_hi_i,
  output logic signed [pfvb_pkg::FaceWidth-1:0]  cur_lo_o,
  output logic signed [pfvb_pkg::FaceWidth-1:0]  cur_hi_o,
  output logic signed [pfvb_pkg::FaceWidth-1:0]  sav_lo_o,
  output logic signed [pfvb_pkg::FaceWidth-1:0]  sav_hi_o
);

  logic [pfvb_pkg::FaceWidth-1:0] cur_mem_q [DEPTH];
  logic [pfvb_pkg::FaceWidth-1:0] sav_mem_q [DEPTH];

  logic [pfvb_pkg::FaceWidth-1:0] cur_lo_q, cur_hi_q, sav_lo_q, sav_hi_q;

  always_ff @(posedge clk_i) begin
    if (we_cur_i) begin
      cur_mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      cur_lo_q <= cur_mem_q[raddr_lo_i];
      cur_hi_q <= cur_mem_q[raddr_hi_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_sav_i) begin
      sav_mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      sav_lo_q <= sav_mem_q[raddr_lo_i];
      sav_hi_q <= sav_mem_q[raddr_hi_i];
    end
  end

  assign cur_lo_o = signed'(cur_lo_q);
  assign cur_hi_o = signed'(cur_hi_q);
  assign sav_lo_o = signed'(sav_lo_q);
  assign sav_hi_o = signed'(sav_hi_q);

endmodule

`default_nettype wire

// ===== rtl/core/pfvb_req_stage.sv =====
// ----------------------------------------------------------------------------
// pfvb_req_stage
// Request register: decodes loads and particles, finds cell and fraction,
// and drives the face store addresses and write enables.
// ----------------------------------------------------------------------------
`default_nettype none

module pfvb_req_stage #(
  parameter int GRID_CELLS = 32,
  localparam int FaceCount = (GRID_CELLS + 1) * GRID_CELLS * GRID_CELLS,
  localparam int AW        = $clog2(FaceCount)
) (
  input  wire logic                                                   clk_i,
  input  wire logic                                                   rst_ni,
  input  wire logic                                                   valid_i,
  output logic                                                        ready_o,
  input  wire logic                                                   en_mem_i,
  input  wire logic [1:0]                                             req_type_i,
  input  wire logic [1:0]                                             axis_i,
  input  wire logic [pfvb_pkg::IdxWidth-1:0]                          face_i_i,
  input  wire logic [pfvb_pkg::IdxWidth-1:0]                          face_j_i,
  input  wire logic [pfvb_pkg::IdxWidth-1:0]                          face_k_i,
  input  wire logic [pfvb_pkg::FaceWidth-1:0]                         load_value_i,
  input  wire logic [pfvb_pkg::NumAxes-1:0][pfvb_pkg::PosWidth-1:0]   pos_i,
  input  wire logic [pfvb_pkg::NumAxes-1:0][pfvb_pkg::FaceWidth-1:0]  old_vel_i,
  output logic                                                        particle_o,
  output logic [pfvb_pkg::NumAxes-1:0]                                we_cur_o,
  output logic [pfvb_pkg::NumAxes-1:0]                                we_sav_o,
  output logic [AW-1:0]                                               waddr_o,
  output logic [pfvb_pkg::FaceWidth-1:0]                              wdata_o,
  output logic [pfvb_pkg::NumAxes-1:0][AW-1:0]                        rd_lo_o,
  output logic [pfvb_pkg::NumAxes-1:0][AW-1:0]                        rd_hi_o,
  output logic [pfvb_pkg::NumAxes-1:0][pfvb_pkg::FracBits-1:0]        frac_o,
  output logic [pfvb_pkg::NumAxes-1:0][pfvb_pkg::FaceWidth-1:0]       old_vel_o
);

  localparam int NA  = pfvb_pkg::NumAxes;
  localparam int FB  = pfvb_pkg::FracBits;
  localparam int IW  = pfvb_pkg::IdxWidth;
  localparam int CW  = $clog2(GRID_CELLS);
  localparam int AIW = $clog2(GRID_CELLS + 1);
  localparam int SW  = FB + CW;
  localparam logic [AW-1:0] LayerStep = AW'(GRID_CELLS * GRID_CELLS);

  function automatic logic [AW-1:0] face_addr(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b,
                                               input logic [AW-1:0] c);
    return (a * AW'(GRID_CELLS) + b) * AW'(GRID_CELLS) + c;
  endfunction

  logic                          valid_q;
  pfvb_pkg::req_type_e           kind_q;
  logic [NA-1:0]                 axis_q;
  logic [AIW-1:0]                la_q;
  logic [CW-1:0]                 lb_q, lc_q;
  logic [pfvb_pkg::FaceWidth-1:0] value_q;
  logic [NA-1:0][CW-1:0]         cell_q;
  logic [NA-1:0][FB-1:0]         frac_q;
  logic [NA-1:0][pfvb_pkg::FaceWidth-1:0] old_q;

  logic [NA-1:0]     ax_hot;
  logic [IW-1:0]     a_raw, b_raw, c_raw;
  logic              in_range, is_load, keep;
  logic [NA-1:0][SW-1:0] scaled;

  always_comb begin
    ax_hot = '0;
    a_raw  = face_i_i;
    b_raw  = face_j_i;
    c_raw  = face_k_i;
    unique case (axis_i)
      pfvb_pkg::AXIS_X: begin
        ax_hot = 3'b001;
      end
      pfvb_pkg::AXIS_Y: begin
        ax_hot = 3'b010;
        a_raw  = face_j_i;
        b_raw  = face_i_i;
      end
      pfvb_pkg::AXIS_Z: begin
        ax_hot = 3'b100;
        a_raw  = face_k_i;
        b_raw  = face_i_i;
        c_raw  = face_j_i;
      end
      default: begin
        ax_hot = '0;
      end
    endcase
    // along-axis index may reach the far boundary face
    in_range = (32'(a_raw) <= 32'(GRID_CELLS)) && (32'(b_raw) < 32'(GRID_CELLS)) &&
               (32'(c_raw) < 32'(GRID_CELLS));
    is_load  = (req_type_i == pfvb_pkg::REQ_LOAD_CUR) ||
               (req_type_i == pfvb_pkg::REQ_LOAD_SAV);
    keep     = (req_type_i == pfvb_pkg::REQ_PARTICLE) ||
               (is_load && (ax_hot != '0) && in_range);
    for (int k = 0; k < NA; k++) begin
      scaled[k] = SW'(pos_i[k]) * SW'(GRID_CELLS);
    end
  end

  assign ready_o = !valid_q || en_mem_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      kind_q  <= pfvb_pkg::req_type_e'(req_type_i);
      axis_q  <= ax_hot;
      la_q    <= AIW'(a_raw);
      lb_q    <= CW'(b_raw);
      lc_q    <= CW'(c_raw);
      value_q <= load_value_i;
      old_q   <= old_vel_i;
      for (int k = 0; k < NA; k++) begin
        cell_q[k] <= scaled[k][SW-1:FB];
        frac_q[k] <= scaled[k][FB-1:0];
      end
    end
  end

  logic step;
  assign step = valid_q && en_mem_i;

  assign particle_o = valid_q && (kind_q == pfvb_pkg::REQ_PARTICLE);
  assign we_cur_o   = {NA{step && (kind_q == pfvb_pkg::REQ_LOAD_CUR)}} & axis_q;
  assign we_sav_o   = {NA{step && (kind_q == pfvb_pkg::REQ_LOAD_SAV)}} & axis_q;
  assign waddr_o    = face_addr(AW'(la_q), AW'(lb_q), AW'(lc_q));
  assign wdata_o    = value_q;

  // each axis reads its own face pair, the other two cells pick the column
  assign rd_lo_o[0] = face_addr(AW'(cell_q[0]), AW'(cell_q[1]), AW'(cell_q[2]));
  assign rd_lo_o[1] = face_addr(AW'(cell_q[1]), AW'(cell_q[0]), AW'(cell_q[2]));
  assign rd_lo_o[2] = face_addr(AW'(cell_q[2]), AW'(cell_q[0]), AW'(cell_q[1]));

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      rd_hi_o[k] = rd_lo_o[k] + LayerStep;
    end
  end

  assign frac_o    = frac_q;
  assign old_vel_o = old_q;

endmodule

`default_nettype wire

// ===== rtl/core/pfvb_axis_blend.sv =====
// ----------------------------------------------------------------------------
// pfvb_axis_blend
// Arithmetic of one axis: lerp of current faces and of the grid change,
// flip velocity, alpha blend, rounding and saturation over four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pfvb_axis_blend #(
  parameter int VEL_WIDTH = 32
) (
  input  wire logic                                     clk_i,
  input  wire pfvb_pkg::stage_en_t                      en_i,
  input  wire logic [pfvb_pkg::FracBits-1:0]            frac_i,
  input  wire logic [pfvb_pkg::FaceWidth-1:0]           old_vel_i,
  input  wire logic signed [pfvb_pkg::FaceWidth-1:0]    cur_lo_i,
  input  wire logic signed [pfvb_pkg::FaceWidth-1:0]    cur_hi_i,
  input  wire logic signed [pfvb_pkg::FaceWidth-1:0]    sav_lo_i,
  input  wire logic signed [pfvb_pkg::FaceWidth-1:0]    sav_hi_i,
  input  wire logic [pfvb_pkg::AlphaWidth-1:0]          alpha_i,
  output logic [VEL_WIDTH-1:0]                          vel_o
);

  localparam int FW    = pfvb_pkg::FaceWidth;
  localparam int FB    = pfvb_pkg::FracBits;
  localparam int WW    = FB + 2;
  localparam int PW    = FW + WW;
  localparam int QW    = FW + 1 + WW;
  localparam int PicW  = FW + 2;
  localparam int FlipW = FW + 3;
  localparam int MW    = FlipW + WW;
  localparam int RW    = MW + 1;

  localparam logic signed [WW-1:0] WeightOne = WW'(64'sd1 <<< FB);
  localparam longint               HalfLsb   = 64'sd1 <<< (FB - 1);
  localparam logic signed [RW-1:0] VelMax    = RW'((64'sd1 <<< (VEL_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] VelMin    = ~VelMax;

  // memory read stage
  logic [FB-1:0]          frac_q;
  logic signed [FW-1:0]   old_q;

  always_ff @(posedge clk_i) begin
    if (en_i.mem) begin
      frac_q <= frac_i;
      old_q  <= signed'(old_vel_i);
    end
  end

  // first multiply stage
  logic signed [WW-1:0]  w0, w1;
  logic signed [FW:0]    d0, d1;
  logic signed [PW-1:0]  p0_d, p1_d, p0_q, p1_q;
  logic signed [QW-1:0]  q0_d, q1_d, q0_q, q1_q;
  logic signed [FW-1:0]  old1_q;

  assign w1   = signed'(WW'(frac_q));
  assign w0   = WeightOne - w1;
  assign d0   = (FW+1)'(cur_lo_i) - (FW+1)'(sav_lo_i);
  assign d1   = (FW+1)'(cur_hi_i) - (FW+1)'(sav_hi_i);
  assign p0_d = PW'(cur_lo_i) * PW'(w0);
  assign p1_d = PW'(cur_hi_i) * PW'(w1);
  assign q0_d = QW'(d0) * QW'(w0);
  assign q1_d = QW'(d1) * QW'(w1);

  always_ff @(posedge clk_i) begin
    if (en_i.mul1) begin
      p0_q   <= p0_d;
      p1_q   <= p1_d;
      q0_q   <= q0_d;
      q1_q   <= q1_d;
      old1_q <= old_q;
    end
  end

  // sum stage: round half up is floor of (x + half) >> 16
  logic signed [PW:0]      psum;
  logic signed [QW:0]      qsum;
  logic signed [PicW-1:0]  pic_d, dflip, pic_q;
  logic signed [FlipW-1:0] flip_d, flip_q;

  assign psum   = (PW+1)'(p0_q) + (PW+1)'(p1_q) + (PW+1)'(HalfLsb);
  assign qsum   = (QW+1)'(q0_q) + (QW+1)'(q1_q) + (QW+1)'(HalfLsb);
  assign pic_d  = signed'(psum[FB +: PicW]);
  assign dflip  = signed'(qsum[FB +: PicW]);
  assign flip_d = FlipW'(old1_q) + FlipW'(dflip);

  always_ff @(posedge clk_i) begin
    if (en_i.sum1) begin
      pic_q  <= pic_d;
      flip_q <= flip_d;
    end
  end

  // blend multiply stage
  logic signed [WW-1:0] aw, bw;
  logic signed [MW-1:0] m0_d, m1_d, m0_q, m1_q;

  assign aw   = signed'(WW'(alpha_i));
  assign bw   = WeightOne - aw;
  assign m0_d = MW'(flip_q) * MW'(aw);
  assign m1_d = MW'(pic_q) * MW'(bw);

  always_ff @(posedge clk_i) begin
    if (en_i.mul2) begin
      m0_q <= m0_d;
      m1_q <= m1_d;
    end
  end

  // result stage
  logic signed [RW-1:0]  rsum, rnd, sat;
  logic [VEL_WIDTH-1:0]  vel_q;

  assign rsum = RW'(m0_q) + RW'(m1_q) + RW'(HalfLsb);
  assign rnd  = rsum >>> FB;

  always_comb begin
    priority if (rnd > VelMax) begin
      sat = VelMax;
    end else if (rnd < VelMin) begin
      sat = VelMin;
    end else begin
      sat = rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.res) begin
      vel_q <= sat[VEL_WIDTH-1:0];
    end
  end

  assign vel_o = vel_q;

endmodule

`default_nettype wire

// ===== rtl/core/pic_flip_velocity_blend_top.sv =====
// ----------------------------------------------------------------------------
// pic_flip_velocity_blend_top
// Grid-to-particle velocity transfer with a pic/flip blend. Face loads fill
// the current and saved grids; each particle request returns one blended
// velocity triple. One request is taken per clock, loads and particles
// alike, unless result back-pressure holds the pipeline. A particle's result
// passes the request register, the registered read of both faces of its cell
// in the per-axis face stores (two read ports each), two multiply stages with
// their sums, and the output register. Loads produce no result and take effect
// for any particle accepted in a later cycle. The face stores have no reset
// and no clearing pass; a face must be loaded before a particle reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module pic_flip_velocity_blend_top #(
  parameter int GRID_CELLS = 32,
  parameter int VEL_WIDTH  = 32,
  localparam int OutDataWidth = ((3 * VEL_WIDTH + 7) / 8) * 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // face_i, face_j, face_k, load_value, pos_x, pos_y, pos_z,
  // old_vel_x, old_vel_y, old_vel_z, zero pad
  input  wire logic [pfvb_pkg::InDataWidth-1:0]    s_tdata,
  // req_type, axis
  input  wire logic [pfvb_pkg::InUserWidth-1:0]    s_tuser,
  // result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // new_vel_x, new_vel_y, new_vel_z, zero pad
  output logic [OutDataWidth-1:0]                  m_tdata,
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  localparam int NA        = pfvb_pkg::NumAxes;
  localparam int FW        = pfvb_pkg::FaceWidth;
  localparam int PosW      = pfvb_pkg::PosWidth;
  localparam int IW        = pfvb_pkg::IdxWidth;
  localparam int FaceCount = (GRID_CELLS + 1) * GRID_CELLS * GRID_CELLS;
  localparam int AW        = $clog2(FaceCount);

  // ---------------------------------------------------------------- config
  logic [pfvb_pkg::AlphaWidth-1:0] alpha_q, alpha_eff;
  logic                            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == pfvb_pkg::RegBlendAlpha);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= pfvb_pkg::AlphaReset;
    end else if (cfg_wr) begin
      alpha_q <= pwdata[pfvb_pkg::AlphaWidth-1:0];
    end
  end

  assign prdata    = (paddr[2] == pfvb_pkg::RegBlendAlpha) ? 32'(alpha_q) : '0;
  assign alpha_eff = (alpha_q > pfvb_pkg::AlphaOne) ? pfvb_pkg::AlphaOne : alpha_q;

  // ---------------------------------------------------------------- control
  pfvb_pkg::stage_en_t en;
  logic v_mem_q, v_mul1_q, v_sum1_q, v_mul2_q, v_res_q;
  logic particle;

  // a stage loads when it is empty or its contents move on
  assign en.res  = !v_res_q || m_tready;
  assign en.mul2 = !v_mul2_q || en.res;
  assign en.sum1 = !v_sum1_q || en.mul2;
  assign en.mul1 = !v_mul1_q || en.sum1;
  assign en.mem  = !v_mem_q || en.mul1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_mem_q  <= 1'b0;
      v_mul1_q <= 1'b0;
      v_sum1_q <= 1'b0;
      v_mul2_q <= 1'b0;
      v_res_q  <= 1'b0;
    end else begin
      if (en.mem) begin
        v_mem_q <= particle;
      end
      if (en.mul1) begin
        v_mul1_q <= v_mem_q;
      end
      if (en.sum1) begin
        v_sum1_q <= v_mul1_q;
      end
      if (en.mul2) begin
        v_mul2_q <= v_sum1_q;
      end
      if (en.res) begin
        v_res_q <= v_mul2_q;
      end
    end
  end

  // ---------------------------------------------------------------- request
  logic [NA-1:0][PosW-1:0]   pos;
  logic [NA-1:0][FW-1:0]     old_vel, old_vel_r;
  logic [NA-1:0]             we_cur, we_sav;
  logic [AW-1:0]             waddr;
  logic [FW-1:0]             wdata;
  logic [NA-1:0][AW-1:0]     rd_lo, rd_hi;
  logic [NA-1:0][pfvb_pkg::FracBits-1:0] frac;

  assign pos[0]     = s_tdata[pfvb_pkg::PosXLsb +: PosW];
  assign pos[1]     = s_tdata[pfvb_pkg::PosYLsb +: PosW];
  assign pos[2]     = s_tdata[pfvb_pkg::PosZLsb +: PosW];
  assign old_vel[0] = s_tdata[pfvb_pkg::OldXLsb +: FW];
  assign old_vel[1] = s_tdata[pfvb_pkg::OldYLsb +: FW];
  assign old_vel[2] = s_tdata[pfvb_pkg::OldZLsb +: FW];

  pfvb_req_stage #(
    .GRID_CELLS (GRID_CELLS)
  ) u_req (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_tvalid),
    .ready_o      (s_tready),
    .en_mem_i     (en.mem),
    .req_type_i   (s_tuser[pfvb_pkg::ReqTypeLsb +: 2]),
    .axis_i       (s_tuser[pfvb_pkg::AxisLsb +: 2]),
    .face_i_i     (s_tdata[pfvb_pkg::FaceILsb +: IW]),
    .face_j_i     (s_tdata[pfvb_pkg::FaceJLsb +: IW]),
    .face_k_i     (s_tdata[pfvb_pkg::FaceKLsb +: IW]),
    .load_value_i (s_tdata[pfvb_pkg::LoadValueLsb +: FW]),
    .pos_i        (pos),
    .old_vel_i    (old_vel),
    .particle_o   (particle),
    .we_cur_o     (we_cur),
    .we_sav_o     (we_sav),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .rd_lo_o      (rd_lo),
    .rd_hi_o      (rd_hi),
    .frac_o       (frac),
    .old_vel_o    (old_vel_r)
  );

  // ---------------------------------------------------------------- axes
  logic [NA-1:0][VEL_WIDTH-1:0] vel;

  for (genvar k = 0; k < NA; k++) begin : g_axis
    logic signed [FW-1:0] cur_lo, cur_hi, sav_lo, sav_hi;

    pfvb_face_mem #(
      .DEPTH (FaceCount),
      .AW    (AW)
    ) u_mem (
      .clk_i      (clk_i),
      .we_cur_i   (we_cur[k]),
      .we_sav_i   (we_sav[k]),
      .waddr_i    (waddr),
      .wdata_i    (wdata),
      .re_i       (en.mem),
      .raddr_lo_i (rd_lo[k]),
      .raddr_hi_i (rd_hi[k]),
      .cur_lo_o   (cur_lo),
      .cur_hi_o   (cur_hi),
      .sav_lo_o   (sav_lo),
      .sav_hi_o   (sav_hi)
    );

    pfvb_axis_blend #(
      .VEL_WIDTH (VEL_WIDTH)
    ) u_blend (
      .clk_i     (clk_i),
      .en_i      (en),
      .frac_i    (frac[k]),
      .old_vel_i (old_vel_r[k]),
      .cur_lo_i  (cur_lo),
      .cur_hi_i  (cur_hi),
      .sav_lo_i  (sav_lo),
      .sav_hi_i  (sav_hi),
      .alpha_i   (alpha_eff),
      .vel_o     (vel[k])
    );
  end

  assign m_tvalid = v_res_q;
  assign m_tdata  = OutDataWidth'(vel);

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pic/flip velocity blend block. Face loads and
// particle requests stream in from a queue while both stream sides back off
// at random; each particle's blended velocity triple is predicted from a
// private copy of the face grids and the blend weight, and compared field by
// field with the result stream. The weight register is reprogrammed and read
// back between traffic phases, with the block drained first.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import pfvb_pkg::*;

  localparam int Cells        = 32;
  localparam int CellSpan     = 65536 / Cells;
  localparam int FaceCount    = (Cells + 1) * Cells * Cells;
  localparam int OutWidth     = 96;
  localparam int HalfPeriod   = 6;
  localparam int SettleCycles = 8;
  localparam int IdlePercent  = 21;
  localparam int PhaseItems   = 125;
  localparam int PrintCap     = 100;

  localparam longint VelMax = 64'sd2147483647;
  localparam longint VelMin = -64'sd2147483648;

  localparam logic [1:0] ReqIgnored = 2'd3;
  localparam logic [1:0] AxisUnused = 2'd3;
  localparam logic [2:0] AddrAlpha  = {RegBlendAlpha, 2'b00};
  localparam logic [2:0] AddrUnused = {~RegBlendAlpha, 2'b00};

  // same layout as s_tdata, first field lowest
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] old_z, old_y, old_x;
    logic [15:0] pos_z, pos_y, pos_x;
    logic [31:0] load_val;
    logic [5:0]  face_k, face_j, face_i;
  } req_data_t;

  typedef struct packed {
    logic [1:0] axis;
    logic [1:0] kind;
  } req_user_t;

  typedef struct packed {
    req_user_t user;
    req_data_t data;
  } request_t;

  // same layout as m_tdata
  typedef struct packed {
    logic [31:0] vz, vy, vx;
  } velocity_t;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [InDataWidth-1:0] s_tdata  = '0;
  logic [InUserWidth-1:0] s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OutWidth-1:0]    m_tdata;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [2:0]             paddr    = '0;
  logic [31:0]            pwdata   = '0;
  logic [31:0]            prdata;
  logic                   pready;

  // predictor state: face grids and the weight register
  int                    cur_vel [3][FaceCount];
  int                    sav_vel [3][FaceCount];
  logic [AlphaWidth-1:0] alpha_reg = AlphaReset;

  request_t    req_pending_q[$];
  velocity_t   vel_expect_q[$];
  logic [14:0] ready_cells[$];
  int          error_count = 0;
  bit          req_fire    = 1'b0;
  bit          no_stall    = 1'b0;

  pic_flip_velocity_blend_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  task automatic flag_error(string what);
    error_count++;
    if (error_count <= PrintCap) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic int face_addr(int a, int b, int c);
    return (a * Cells + b) * Cells + c;
  endfunction

  // half-up rounding of a q16 product back to the velocity scale
  function automatic longint round_q16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic logic [31:0] blend_axis(int c0, int c1, int s0, int s1, longint t,
                                             int old, longint alpha);
    longint d0, d1, pic, dflip, v;
    d0    = longint'(c0) - longint'(s0);
    d1    = longint'(c1) - longint'(s1);
    pic   = round_q16((64'sd65536 - t) * longint'(c0) + t * longint'(c1));
    dflip = round_q16((64'sd65536 - t) * d0 + t * d1);
    v     = round_q16(alpha * (longint'(old) + dflip) + (64'sd65536 - alpha) * pic);
    if (v > VelMax) v = VelMax;
    if (v < VelMin) v = VelMin;
    return v[31:0];
  endfunction

  // ---------------------------------------------------------------- driver
  always @(negedge clk_i) begin : driver
    request_t rq;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_fire) begin
      if (req_pending_q.size() != 0 && (no_stall || $urandom_range(99) >= IdlePercent)) begin
        rq = req_pending_q.pop_front();
        s_tdata  <= rq.data;
        s_tuser  <= rq.user;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= no_stall || ($urandom_range(99) >= IdlePercent);
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk_i) begin : monitor
    request_t  rq;
    velocity_t got, want;
    int        a, b, c, sx, sy, sz, ci, cj, ck;
    longint    alpha;
    req_fire = s_tvalid && s_tready;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (vel_expect_q.size() == 0) begin
          flag_error($sformatf("result %h with nothing expected", m_tdata));
        end else begin
          want = vel_expect_q.pop_front();
          if (got.vx !== want.vx) flag_error($sformatf("vel x %h, want %h", got.vx, want.vx));
          if (got.vy !== want.vy) flag_error($sformatf("vel y %h, want %h", got.vy, want.vy));
          if (got.vz !== want.vz) flag_error($sformatf("vel z %h, want %h", got.vz, want.vz));
        end
      end
      if (req_fire) begin
        rq.data = s_tdata;
        rq.user = s_tuser;
        if ((rq.user.kind == REQ_LOAD_CUR || rq.user.kind == REQ_LOAD_SAV) &&
            rq.user.axis != AxisUnused) begin
          case (rq.user.axis)
            AXIS_X: begin
              a = int'(rq.data.face_i);
              b = int'(rq.data.face_j);
              c = int'(rq.data.face_k);
            end
            AXIS_Y: begin
              a = int'(rq.data.face_j);
              b = int'(rq.data.face_i);
              c = int'(rq.data.face_k);
            end
            default: begin
              a = int'(rq.data.face_k);
              b = int'(rq.data.face_i);
              c = int'(rq.data.face_j);
            end
          endcase
          // out-of-range faces are dropped
          if (a <= Cells && b < Cells && c < Cells) begin
            if (rq.user.kind == REQ_LOAD_CUR) cur_vel[rq.user.axis][face_addr(a, b, c)] =
                rq.data.load_val;
            else sav_vel[rq.user.axis][face_addr(a, b, c)] = rq.data.load_val;
          end
        end else if (rq.user.kind == REQ_PARTICLE) begin
          sx = int'(rq.data.pos_x);
          sy = int'(rq.data.pos_y);
          sz = int'(rq.data.pos_z);
          sx = sx * Cells;
          sy = sy * Cells;
          sz = sz * Cells;
          ci = sx >> 16;
          cj = sy >> 16;
          ck = sz >> 16;
          alpha = longint'((alpha_reg > AlphaOne) ? AlphaOne : alpha_reg);
          want.vx = blend_axis(cur_vel[AXIS_X][face_addr(ci, cj, ck)],
                               cur_vel[AXIS_X][face_addr(ci + 1, cj, ck)],
                               sav_vel[AXIS_X][face_addr(ci, cj, ck)],
                               sav_vel[AXIS_X][face_addr(ci + 1, cj, ck)],
                               longint'(sx & 32'hFFFF), rq.data.old_x, alpha);
          want.vy = blend_axis(cur_vel[AXIS_Y][face_addr(cj, ci, ck)],
                               cur_vel[AXIS_Y][face_addr(cj + 1, ci, ck)],
                               sav_vel[AXIS_Y][face_addr(cj, ci, ck)],
                               sav_vel[AXIS_Y][face_addr(cj + 1, ci, ck)],
                               longint'(sy & 32'hFFFF), rq.data.old_y, alpha);
          want.vz = blend_axis(cur_vel[AXIS_Z][face_addr(ck, ci, cj)],
                               cur_vel[AXIS_Z][face_addr(ck + 1, ci, cj)],
                               sav_vel[AXIS_Z][face_addr(ck, ci, cj)],
                               sav_vel[AXIS_Z][face_addr(ck + 1, ci, cj)],
                               longint'(sz & 32'hFFFF), rq.data.old_z, alpha);
          vel_expect_q = {vel_expect_q, want};
        end
      end
    end
  end

  // ------------------------------------------------------------ apb access
  task automatic apb_write(logic [2:0] addr, logic [31:0] word);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == AddrAlpha) alpha_reg = word[AlphaWidth-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_alpha_readback();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrAlpha;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(32 - AlphaWidth){1'b0}}, alpha_reg})
      flag_error($sformatf("alpha readback %h, want %h", prdata, alpha_reg));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // a write to the unused address must not disturb the weight
  task automatic program_alpha(logic [31:0] word);
    apb_write(AddrUnused, $urandom());
    apb_write(AddrAlpha, word);
    check_alpha_readback();
  endtask

  // ------------------------------------------------------------- stimulus
  function automatic logic [31:0] pick_vel();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom_range(2097152) - 32'd1048576;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_load(logic [1:0] kind, logic [1:0] axis, int fi, int fj, int fk,
                           logic [31:0] val);
    request_t rq;
    rq = '0;
    rq.user.kind     = kind;
    rq.user.axis     = axis;
    rq.data.face_i   = 6'(fi);
    rq.data.face_j   = 6'(fj);
    rq.data.face_k   = 6'(fk);
    rq.data.load_val = val;
    req_pending_q = {req_pending_q, rq};
  endtask

  task automatic push_particle(int px, int py, int pz, logic [31:0] ox, logic [31:0] oy,
                               logic [31:0] oz);
    request_t rq;
    rq = '0;
    rq.user.kind  = REQ_PARTICLE;
    rq.data.pos_x = 16'(px);
    rq.data.pos_y = 16'(py);
    rq.data.pos_z = 16'(pz);
    rq.data.old_x = ox;
    rq.data.old_y = oy;
    rq.data.old_z = oz;
    req_pending_q = {req_pending_q, rq};
  endtask

  // loads both faces of every axis in both grids, so particles may use the cell
  task automatic fill_cell(int ci, int cj, int ck, bit pinned,
                           logic [31:0] cur_word = '0, logic [31:0] sav_word = '0);
    logic [1:0]  kind;
    logic [31:0] val;
    for (int g = 0; g < 2; g++) begin
      kind = (g == 0) ? REQ_LOAD_CUR : REQ_LOAD_SAV;
      for (int h = 0; h < 2; h++) begin
        val = pinned ? ((g == 0) ? cur_word : sav_word) : pick_vel();
        push_load(kind, AXIS_X, ci + h, cj, ck, val);
        val = pinned ? ((g == 0) ? cur_word : sav_word) : pick_vel();
        push_load(kind, AXIS_Y, ci, cj + h, ck, val);
        val = pinned ? ((g == 0) ? cur_word : sav_word) : pick_vel();
        push_load(kind, AXIS_Z, ci, cj, ck + h, val);
      end
    end
    ready_cells = {ready_cells, {5'(ci), 5'(cj), 5'(ck)}};
  endtask

  function automatic int pick_frac();
    case ($urandom_range(7))
      0: return 0;
      1: return CellSpan - 1;
      default: return $urandom_range(CellSpan - 1);
    endcase
  endfunction

  task automatic gen_phase(int n);
    int          made, pick, fi, fj, fk;
    logic [1:0]  kind, axis;
    logic [14:0] pick_cell;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 8 || ready_cells.size() == 0) begin
        fill_cell($urandom_range(Cells - 1), $urandom_range(Cells - 1),
                  $urandom_range(Cells - 1), 1'b0);
        made += 12;
      end else if (pick < 72) begin
        pick_cell = ready_cells[$urandom_range(ready_cells.size() - 1)];
        push_particle(int'(pick_cell[14:10]) * CellSpan + pick_frac(),
                      int'(pick_cell[9:5]) * CellSpan + pick_frac(),
                      int'(pick_cell[4:0]) * CellSpan + pick_frac(),
                      pick_vel(), pick_vel(), pick_vel());
        made++;
      end else if (pick < 87) begin
        // overwrite one in-range face
        kind = $urandom_range(1) ? REQ_LOAD_SAV : REQ_LOAD_CUR;
        axis = 2'($urandom_range(2));
        fi = $urandom_range(axis == AXIS_X ? Cells : Cells - 1);
        fj = $urandom_range(axis == AXIS_Y ? Cells : Cells - 1);
        fk = $urandom_range(axis == AXIS_Z ? Cells : Cells - 1);
        push_load(kind, axis, fi, fj, fk, pick_vel());
        made++;
      end else begin
        // any load encoding, or the unused request code; never a particle
        case ($urandom_range(2))
          0: kind = REQ_LOAD_CUR;
          1: kind = REQ_LOAD_SAV;
          default: kind = ReqIgnored;
        endcase
        push_load(kind, 2'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                  $urandom_range(63), $urandom());
        made++;
      end
    end
  endtask

  task automatic settle_idle();
    while (req_pending_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (vel_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : sequencer
    logic [31:0] alpha_plan[6];
    alpha_plan = '{32'd0, 32'd65536, 32'h0001_FFFF, $urandom_range(65536),
                   32'hABCC_8000, 32'(AlphaReset)};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    check_alpha_readback();

    // corner cells with extreme faces drive both saturation limits
    fill_cell(0, 0, 0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    fill_cell(Cells - 1, Cells - 1, Cells - 1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    // ignored requests aimed at faces of cell zero
    push_load(REQ_LOAD_CUR, AxisUnused, 0, 0, 0, 32'h1234_5678);
    push_load(REQ_LOAD_CUR, AXIS_X, 0, Cells, 0, 32'h1234_5678);
    push_load(REQ_LOAD_SAV, AXIS_Y, 0, Cells + 1, 0, 32'h1234_5678);
    push_load(ReqIgnored, AXIS_Z, 0, 0, 0, 32'h1234_5678);
    push_particle(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_particle(CellSpan - 1, CellSpan - 1, CellSpan - 1, 32'h8000_0000, 32'h0, 32'h1);
    push_particle(65535, 65535, 65535, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_particle(65536 - CellSpan, 65535, 65536 - CellSpan, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    settle_idle();

    for (int ph = 0; ph < 6; ph++) begin
      program_alpha(alpha_plan[ph]);
      no_stall = (ph == 2);
      gen_phase(PhaseItems);
      settle_idle();
    end

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(2 * HalfPeriod * 200000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
